// File: hw/rtl/rc4_pkg.sv
// ============================================================================
// rc4_pkg: shared types, constants and microcode for the RC4 stream cipher
// Step codes, control word layout, datapath status and the control store.
// ============================================================================
`default_nettype none

package rc4_pkg;

  localparam int TABLE_SIZE        = 256;
  localparam int PERM_AW           = 8;
  localparam int KEY_BYTES_MAX_DEF = 256;

  // Microcode step addresses; fall-through goes to the next code.
  typedef enum logic [3:0] {
    S_CLR  = 4'd0,
    S_IDLE = 4'd1,
    S_D1   = 4'd2,
    S_D2   = 4'd3,
    S_D3   = 4'd4,
    S_FILL = 4'd5,
    S_K0   = 4'd6,
    S_K1   = 4'd7,
    S_K2   = 4'd8,
    S_K3   = 4'd9,
    S_FIN  = 4'd10
  } step_t;

  // Permutation read address source.
  typedef enum logic [2:0] {
    RD_I1   = 3'd0,  // i + 1
    RD_JSUM = 3'd1,  // j + S[i]
    RD_TSUM = 3'd2,  // S[i] + S[j]
    RD_TREG = 3'd3,  // saved keystream index
    RD_N    = 3'd4,  // sweep counter
    RD_ACC  = 3'd5   // acc + S[n] + key byte
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_N   = 2'd0,
    WA_I   = 2'd1,
    WA_J   = 2'd2,
    WA_ACC = 2'd3
  } wa_sel_t;

  typedef enum logic [1:0] {
    WD_ZERO  = 2'd0,
    WD_N     = 2'd1,
    WD_RDATA = 2'd2,
    WD_HOLD  = 2'd3
  } wd_sel_t;

  typedef enum logic [2:0] {
    JC_NEXT     = 3'd0,  // fall through
    JC_GO       = 3'd1,  // unconditional jump
    JC_LOOP_N   = 3'd2,  // jump while the sweep counter is not at its end
    JC_DISPATCH = 3'd3,  // decode an accepted beat
    JC_WAIT_OUT = 3'd4   // jump once the output register is free, else hold
  } jc_t;

  typedef struct packed {
    logic    accept;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    load_hold;
    logic    load_sj;
    logic    load_j;
    logic    load_t;
    logic    emit;
    logic    n_inc;
    logic    key_step;
    logic    acc_load;
    logic    finish;
    jc_t     jc;
    step_t   target;
  } ctrl_t;

  typedef struct packed {
    logic n_more;
    logic out_free;
  } status_t;

  // Control store: one word per step.
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '0;
    unique case (s)
      S_CLR: begin
        c.wr_en  = 1'b1;
        c.wa_sel = WA_N;
        c.wd_sel = WD_ZERO;
        c.n_inc  = 1'b1;
        c.jc     = JC_LOOP_N;
        c.target = S_CLR;
      end
      S_IDLE: begin
        c.accept = 1'b1;
        c.rd_sel = RD_I1;
        c.jc     = JC_DISPATCH;
        c.target = S_IDLE;
      end
      S_D1: begin
        c.rd_sel    = RD_JSUM;
        c.load_hold = 1'b1;
        c.load_j    = 1'b1;
        c.jc        = JC_NEXT;
      end
      S_D2: begin
        c.rd_sel  = RD_TSUM;
        c.wr_en   = 1'b1;
        c.wa_sel  = WA_I;
        c.wd_sel  = WD_RDATA;
        c.load_sj = 1'b1;
        c.load_t  = 1'b1;
        c.jc      = JC_NEXT;
      end
      S_D3: begin
        c.rd_sel = RD_TREG;
        c.wr_en  = 1'b1;
        c.wa_sel = WA_J;
        c.wd_sel = WD_HOLD;
        c.emit   = 1'b1;
        c.jc     = JC_WAIT_OUT;
        c.target = S_IDLE;
      end
      S_FILL: begin
        c.wr_en  = 1'b1;
        c.wa_sel = WA_N;
        c.wd_sel = WD_N;
        c.n_inc  = 1'b1;
        c.jc     = JC_LOOP_N;
        c.target = S_FILL;
      end
      S_K0: begin
        c.rd_sel = RD_N;
        c.jc     = JC_NEXT;
      end
      S_K1: begin
        c.rd_sel    = RD_ACC;
        c.load_hold = 1'b1;
        c.acc_load  = 1'b1;
        c.jc        = JC_NEXT;
      end
      S_K2: begin
        c.wr_en  = 1'b1;
        c.wa_sel = WA_N;
        c.wd_sel = WD_RDATA;
        c.jc     = JC_NEXT;
      end
      S_K3: begin
        c.wr_en    = 1'b1;
        c.wa_sel   = WA_ACC;
        c.wd_sel   = WD_HOLD;
        c.n_inc    = 1'b1;
        c.key_step = 1'b1;
        c.jc       = JC_LOOP_N;
        c.target   = S_K0;
      end
      S_FIN: begin
        c.finish = 1'b1;
        c.jc     = JC_GO;
        c.target = S_IDLE;
      end
      default: begin
        c.jc     = JC_GO;
        c.target = S_CLR;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rc4_if.sv
// ============================================================================
// rc4 stream interfaces
// Valid/ready channels for command beats in and cipher beats out.
// ============================================================================
`default_nettype none

interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] payload_byte;
  logic       is_last;

  modport source (output valid, output command, output payload_byte, output is_last,
                  input ready);
  modport sink   (input valid, input command, input payload_byte, input is_last,
                  output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rc4_ram.sv
// ============================================================================
// rc4_ram: generic simple dual-port RAM
// One write port, one read port, registered read-first data.
// ============================================================================
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/rc4_seq.sv
// ============================================================================
// rc4_seq: microcode sequencer
// Step counter, control store lookup and conditional jumps.
// ============================================================================
`default_nettype none

module rc4_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_command,
  input  wire logic             in_last,
  input  wire rc4_pkg::status_t status,
  output rc4_pkg::ctrl_t        ctrl
);
  import rc4_pkg::*;

  step_t step;
  step_t step_next;
  step_t step_fall;

  assign step_fall = step_t'(4'(step) + 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_CLR;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl = ucode(step);
  end

  always_comb begin
    step_next = step_fall;
    unique case (ctrl.jc)
      JC_NEXT:     step_next = step_fall;
      JC_GO:       step_next = ctrl.target;
      JC_LOOP_N:   step_next = status.n_more ? ctrl.target : step_fall;
      JC_DISPATCH: begin
        if (!in_valid) begin
          step_next = ctrl.target;
        end else if (in_command) begin
          step_next = S_D1;
        end else if (in_last) begin
          step_next = S_FILL;
        end else begin
          step_next = ctrl.target;
        end
      end
      JC_WAIT_OUT: step_next = status.out_free ? ctrl.target : step;
      default:     step_next = S_CLR;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/rc4_dp.sv
// ============================================================================
// rc4_dp: cipher datapath
// Permutation and key RAMs, index registers and the output register.
// ============================================================================
`default_nettype none

module rc4_dp #(
  parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rc4_pkg::ctrl_t ctrl,
  output rc4_pkg::status_t    status,
  input  wire logic           in_valid,
  input  wire logic           in_command,
  input  wire logic [7:0]     in_payload,
  input  wire logic           in_last,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import rc4_pkg::*;

  localparam int KIDX_W = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
  localparam int KCNT_W = $clog2(KEY_BYTES_MAX + 1);
  localparam logic [KCNT_W-1:0] KEY_MAX_C = KCNT_W'(KEY_BYTES_MAX);

  logic [7:0]        idx_i;
  logic [7:0]        idx_j;
  logic [7:0]        hold;
  logic [7:0]        sj;
  logic [7:0]        t_reg;
  logic [7:0]        n;
  logic [7:0]        acc;
  logic [KIDX_W-1:0] kidx;
  logic [KCNT_W-1:0] key_count;
  logic [7:0]        data_byte;
  logic              data_last;

  logic [PERM_AW-1:0] perm_rd_addr;
  logic [PERM_AW-1:0] perm_wr_addr;
  logic [7:0]         perm_wr_data;
  logic [7:0]         perm_rdata;
  logic [7:0]         key_rdata;
  logic               key_wr_en;

  logic [7:0]        i_plus;
  logic [7:0]        j_sum;
  logic [7:0]        t_sum;
  logic [7:0]        acc_sum;
  logic [7:0]        ks;
  logic              take;
  logic              emit_fire;
  logic [KCNT_W-1:0] key_len;
  logic [KCNT_W-1:0] kidx_inc;
  logic              kidx_wrap;

  assign take      = ctrl.accept && in_valid;
  assign key_wr_en = take && !in_command && (key_count < KEY_MAX_C);

  assign i_plus  = idx_i + 8'd1;
  assign j_sum   = idx_j + perm_rdata;
  assign t_sum   = hold + perm_rdata;
  assign acc_sum = acc + perm_rdata + key_rdata;

  // Zero-length key behaves as a single byte.
  assign key_len   = (key_count == '0) ? KCNT_W'(1) : key_count;
  assign kidx_inc  = KCNT_W'(kidx) + KCNT_W'(1);
  assign kidx_wrap = (kidx_inc >= key_len);

  // Both swap writes may not have landed when S[t] was read: bypass them.
  assign ks = (t_reg == idx_j) ? hold :
              (t_reg == idx_i) ? sj   : perm_rdata;

  assign status.n_more   = (n != 8'hFF);
  assign status.out_free = !out_valid || out_ready;
  assign emit_fire       = ctrl.emit && status.out_free;

  always_comb begin
    case (ctrl.rd_sel)
      RD_I1:   perm_rd_addr = i_plus;
      RD_JSUM: perm_rd_addr = j_sum;
      RD_TSUM: perm_rd_addr = t_sum;
      RD_TREG: perm_rd_addr = t_reg;
      RD_N:    perm_rd_addr = n;
      RD_ACC:  perm_rd_addr = acc_sum;
      default: perm_rd_addr = n;
    endcase
  end

  always_comb begin
    case (ctrl.wa_sel)
      WA_N:    perm_wr_addr = n;
      WA_I:    perm_wr_addr = idx_i;
      WA_J:    perm_wr_addr = idx_j;
      WA_ACC:  perm_wr_addr = acc;
      default: perm_wr_addr = n;
    endcase
  end

  always_comb begin
    case (ctrl.wd_sel)
      WD_ZERO:  perm_wr_data = 8'd0;
      WD_N:     perm_wr_data = n;
      WD_RDATA: perm_wr_data = perm_rdata;
      WD_HOLD:  perm_wr_data = hold;
      default:  perm_wr_data = 8'd0;
    endcase
  end

  rc4_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_SIZE)
  ) u_perm (
    .clk     (clk),
    .wr_en   (ctrl.wr_en),
    .wr_addr (perm_wr_addr),
    .wr_data (perm_wr_data),
    .rd_addr (perm_rd_addr),
    .rd_data (perm_rdata)
  );

  rc4_ram #(
    .WIDTH (8),
    .DEPTH (KEY_BYTES_MAX)
  ) u_key (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_count[KIDX_W-1:0]),
    .wr_data (in_payload),
    .rd_addr (kidx),
    .rd_data (key_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i     <= 8'd0;
      idx_j     <= 8'd0;
      n         <= 8'd0;
      acc       <= 8'd0;
      kidx      <= '0;
      key_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take && in_command) begin
        idx_i <= i_plus;
      end
      if (ctrl.load_j) begin
        idx_j <= j_sum;
      end
      if (key_wr_en) begin
        key_count <= key_count + KCNT_W'(1);
      end
      if (ctrl.n_inc) begin
        n <= n + 8'd1;
      end
      if (ctrl.acc_load) begin
        acc <= acc_sum;
      end
      if (ctrl.key_step) begin
        kidx <= kidx_wrap ? '0 : kidx_inc[KIDX_W-1:0];
      end
      if (ctrl.finish) begin
        idx_i     <= 8'd0;
        idx_j     <= 8'd0;
        acc       <= 8'd0;
        kidx      <= '0;
        key_count <= '0;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      data_byte <= in_payload;
      data_last <= in_last;
    end
    if (ctrl.load_hold) begin
      hold <= perm_rdata;
    end
    if (ctrl.load_sj) begin
      sj <= perm_rdata;
    end
    if (ctrl.load_t) begin
      t_reg <= t_sum;
    end
    if (emit_fire) begin
      out_byte <= data_byte ^ ks;
      out_last <= data_last;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rc4_stream_cipher.sv
// A data beat's result is loaded into the output register by its final step.
// Data beats read S[i], S[j], S[t] in turn through the single read port of the
// permutation RAM and hold the input not ready until done; a plain key beat
// leaves the sequencer on the dispatch step. A key beat flagged last starts the
// key schedule: the fill sweep, 256 rounds of steps K0 to K3 and a final step.
// Input not ready meanwhile. Reset: a clearing pass zeroes the permutation RAM.
// ============================================================================
// rc4_stream_cipher: RC4 stream cipher top level
// Microcoded sequencer driving a RAM-based permutation datapath.
// ============================================================================
`default_nettype none

module rc4_stream_cipher #(
  parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  rc4_in_if.sink    in_stream,
  rc4_out_if.source out_stream
);
  import rc4_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // The sequencer steps through the control store. It idles on the dispatch
  // step, which is the only step that takes an input beat; a data beat then
  // runs three more steps, a last key beat runs the fill sweep, the 256
  // schedule rounds and a final step that clears the indices and key count.
  rc4_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_stream.valid),
    .in_command (in_stream.command),
    .in_last    (in_stream.is_last),
    .status     (status),
    .ctrl       (ctrl)
  );

  // Accept only on the dispatch step; a pending result in the output
  // register does not hold off the next beat, only the final data step.
  assign in_stream.ready = ctrl.accept;

  // The datapath holds both RAMs, the i/j/acc/sweep registers and the output
  // register that parts the two sides.
  rc4_dp #(
    .KEY_BYTES_MAX (KEY_BYTES_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .status     (status),
    .in_valid   (in_stream.valid),
    .in_command (in_stream.command),
    .in_payload (in_stream.payload_byte),
    .in_last    (in_stream.is_last),
    .out_valid  (out_stream.valid),
    .out_ready  (out_stream.ready),
    .out_byte   (out_stream.out_byte),
    .out_last   (out_stream.out_last)
  );

endmodule

`default_nettype wire

// File: hw/rtl/rc4_checker.sv
// ============================================================================
// rc4_checker: port-level checks for the RC4 stream cipher
// Watches the top-level channels; attached by bind.
// ============================================================================
`default_nettype none

module rc4_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_command,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("result payload changed while stalled");

  // The clearing pass keeps the input closed right after reset.
  a_clear_pass: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input ready during clearing pass");

  // After a plain key beat the input stays ready.
  a_key_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_command && !in_last |=> in_ready)
    else $error("input closed after a plain key beat");

  // A data beat or a last key beat starts a run that closes the input.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_command || in_last) |=> !in_ready)
    else $error("input ready right after a data or last key beat");

endmodule

bind rc4_stream_cipher rc4_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_stream.valid),
  .in_ready   (in_stream.ready),
  .in_command (in_stream.command),
  .in_last    (in_stream.is_last),
  .out_valid  (out_stream.valid),
  .out_ready  (out_stream.ready),
  .out_byte   (out_stream.out_byte),
  .out_last   (out_stream.out_last)
);

`default_nettype wire
